// ===== rtl/core/mac_lookup_cache_with_expiry_core_assert.svh =====
// ----------------------------------------------------------------------------
// MAC lookup cache assertion macros
// Shared concurrent-assertion forms used by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef MAC_LOOKUP_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH
`define MAC_LOOKUP_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MLCE_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlce_pkg.sv =====
// ----------------------------------------------------------------------------
// mlce_pkg
// Types and constants of the IP-to-MAC lookup cache.
// ----------------------------------------------------------------------------
package mlce_pkg;

    // Geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 32;
    localparam int VALID_W  = 17;
    localparam int EXPIRY_W = TIME_W + 1;

    // Validity period after reset, in seconds
    localparam logic [VALID_W-1:0] VALID_RESET = 17'd60;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_HIT  = 2'd0,
        STAT_NEG  = 2'd1,
        STAT_INS  = 2'd2,
        STAT_FAIL = 2'd3
    } t_status;

    // Lookup sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Lookup key after family masking
    typedef struct packed {
        logic              is_v6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } t_key;

    // One stored cache entry
    typedef struct packed {
        t_key                key;
        logic [MAC_W-1:0]    mac;
        logic                found;
        logic [EXPIRY_W-1:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Finished result
    typedef struct packed {
        t_status          status;
        logic [MAC_W-1:0] mac;
    } t_res;

    // Entry store write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

endpackage

// ===== rtl/core/mlce_req_if.sv =====
// ----------------------------------------------------------------------------
// mlce_req_if
// Lookup request channel: valid/ready handshake with address, time and
// resolver outcome.
// ----------------------------------------------------------------------------
interface mlce_req_if import mlce_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              address_is_v6;
    logic [ADDR_W-1:0] address_high;
    logic [ADDR_W-1:0] address_low;
    logic [TIME_W-1:0] current_time;
    logic              resolver_ok;
    logic [MAC_W-1:0]  resolver_mac;

    modport source (
        output valid, address_is_v6, address_high, address_low,
               current_time, resolver_ok, resolver_mac,
        input  ready
    );

    modport sink (
        input  valid, address_is_v6, address_high, address_low,
               current_time, resolver_ok, resolver_mac,
        output ready
    );

endinterface

// ===== rtl/core/mlce_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mlce_rsp_if
// Lookup result channel: valid/ready handshake with status and MAC.
// ----------------------------------------------------------------------------
interface mlce_rsp_if import mlce_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [MAC_W-1:0] mac_address;

    modport source (
        output valid, status, mac_address,
        input  ready
    );

    modport sink (
        input  valid, status, mac_address,
        output ready
    );

endinterface

// ===== rtl/core/mac_lookup_cache_with_expiry_core.sv =====
// ----------------------------------------------------------------------------
// mac_lookup_cache_with_expiry_core
// Fully associative IP-to-MAC lookup cache with per-entry expiry and FIFO
// replacement.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one lookup per transaction: address family, 128-bit
//   address, current time and the resolver outcome used on a miss.
//   o_rsp returns one result per lookup: status and MAC.
//   i_cfg_we/i_cfg_wdata write the validity period (seconds); write it only
//   while no lookup is in flight.
// Sequencing:
//   One lookup is in flight at a time. The entry store is read one entry
//   per cycle starting at the insert pointer; a scan ends at the first hit
//   or, on a miss, after all CACHE_ENTRIES entries. The next lookup is
//   taken the cycle after the result moves into the output register. The
//   scan through the single-read-port entry RAM sets the lookup rate.
// Reset:
//   All entries become unused, the insert pointer returns to zero and the
//   validity period to 60 seconds. No clearing pass is needed.
// Stall:
//   The output register holds a result until o_rsp.ready; meanwhile the
//   next lookup is accepted and scanned, then waits for the register.
// ----------------------------------------------------------------------------
module mac_lookup_cache_with_expiry_core import mlce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [VALID_W-1:0] i_cfg_wdata,
    mlce_req_if.sink           i_req,
    mlce_rsp_if.source         o_rsp
);

    logic [VALID_W-1:0] r_validity;
    logic               r_out_vld;
    t_res               r_out;

    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_mem_wr            mem_wr;
    logic               res_vld;
    t_res               res;
    logic               res_take;

    // Validity period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_validity <= VALID_RESET;
        end else if (i_cfg_we) begin
            r_validity <= i_cfg_wdata;
        end
    end

    // Lookup sequencer
    mlce_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_validity (r_validity),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr       (mem_wr),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // Entry store
    mlce_ram #(
        .DEPTH (CACHE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.en),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Output register: load when empty or being drained
    assign res_take = res_vld && (!r_out_vld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.mac_address = r_out.mac;

endmodule

// ===== rtl/core/mlce_ram.sv =====
// ----------------------------------------------------------------------------
// mlce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mlce_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mlce_scan.sv =====
// ----------------------------------------------------------------------------
// mlce_scan
// Lookup sequencer: walks the entry store from the insert pointer, one entry
// per cycle, and inserts the resolver outcome on a miss.
// ----------------------------------------------------------------------------
`include "mac_lookup_cache_with_expiry_core_assert.svh"

module mlce_scan import mlce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mlce_req_if.sink           i_req,
    input  logic [VALID_W-1:0] i_validity,
    output logic [IDX_W-1:0]   o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output t_mem_wr            o_wr,
    output logic               o_res_vld,
    output t_res               o_res,
    input  logic               i_res_take
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

    // Ring increment, wraps at the entry count
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_LAST) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    t_state                   r_state, n_state;
    logic [CACHE_ENTRIES-1:0] r_used, n_used;
    logic [IDX_W-1:0]         r_ptr, n_ptr;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]         r_cnt, n_cnt;
    t_key                     r_key, n_key;
    logic [TIME_W-1:0]        r_now, n_now;
    logic                     r_ok, n_ok;
    logic [MAC_W-1:0]         r_rmac, n_rmac;
    t_res                     r_res, n_res;

    t_entry entry;
    logic   accept;
    logic   hit;
    logic   last;

    assign entry  = t_entry'(i_rd_data);
    assign accept = i_req.valid && i_req.ready;
    assign last   = (r_cnt == IDX_LAST);

    // Entry compare: used, not expired, same family and address
    assign hit = r_used[r_cmp_idx]
              && (entry.expiry >= {1'b0, r_now})
              && (entry.key.is_v6 == r_key.is_v6)
              && (entry.key.addr_high == r_key.addr_high)
              && (entry.key.addr_low == r_key.addr_low);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_used    = r_used;
        n_ptr     = r_ptr;
        n_cmp_idx = r_cmp_idx;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_now     = r_now;
        n_ok      = r_ok;
        n_rmac    = r_rmac;
        n_res     = r_res;
        o_wr      = '0;
        i_req.ready = 1'b0;
        o_res_vld = 1'b0;
        o_rd_addr = idx_inc(r_cmp_idx);
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                o_rd_addr   = r_ptr;
                if (accept) begin
                    // Capture the key; IPv4 keeps only the low 32 bits
                    n_key.is_v6     = i_req.address_is_v6;
                    n_key.addr_high = i_req.address_is_v6 ? i_req.address_high : '0;
                    n_key.addr_low  = i_req.address_is_v6 ? i_req.address_low
                                    : {32'd0, i_req.address_low[31:0]};
                    n_now     = i_req.current_time;
                    n_ok      = i_req.resolver_ok;
                    n_rmac    = i_req.resolver_mac;
                    n_cmp_idx = r_ptr;
                    n_cnt     = '0;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_res.status = entry.found ? STAT_HIT : STAT_NEG;
                    n_res.mac    = entry.found ? entry.mac : '0;
                end else if (last) begin
                    // Miss: overwrite the oldest slot
                    o_wr.en          = 1'b1;
                    o_wr.addr        = r_ptr;
                    o_wr.data.key    = r_key;
                    o_wr.data.found  = r_ok;
                    o_wr.data.mac    = r_ok ? r_rmac : '0;
                    o_wr.data.expiry = {1'b0, r_now}
                                     + {{(EXPIRY_W-VALID_W){1'b0}}, i_validity};
                    n_used[r_ptr]    = 1'b1;
                    n_ptr            = idx_inc(r_ptr);
                    n_res.status     = r_ok ? STAT_INS : STAT_FAIL;
                    n_res.mac        = r_ok ? r_rmac : '0;
                end else begin
                    n_cmp_idx = idx_inc(r_cmp_idx);
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                o_res_vld = 1'b1;
            end
            default: begin
                o_res_vld = 1'b0;
            end
        endcase
    end

    assign o_res = r_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ptr   <= n_ptr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_cnt     <= n_cnt;
        r_key     <= n_key;
        r_now     <= n_now;
        r_ok      <= n_ok;
        r_rmac    <= n_rmac;
        r_res     <= n_res;
    end

    // Checks
    `MLCE_ASSERT_NEXT(a_insert_marks_used, i_clk, i_rst_n, o_wr.en, r_used[$past(r_ptr)], "inserted slot not marked used")
    `MLCE_ASSERT_HOLD(a_hit_from_used, i_clk, i_rst_n, (r_state == ST_DONE && $past(r_state) == ST_SCAN && (r_res.status == STAT_HIT || r_res.status == STAT_NEG)), $past(r_used[r_cmp_idx]), "hit reported on unused slot")
    `MLCE_ASSERT_HOLD(a_neg_mac_zero, i_clk, i_rst_n, (r_state == ST_DONE && (r_res.status == STAT_NEG || r_res.status == STAT_FAIL)), (r_res.mac == '0), "negative result carries a MAC")
    `MLCE_ASSERT_HOLD(a_ptr_hold_done, i_clk, i_rst_n, (r_state == ST_DONE && $past(r_state) == ST_DONE), $stable(r_ptr), "insert pointer moved while waiting")

endmodule
